>>> sv/bpa_pkg.sv
// Package for the bitmap port allocator: opcodes, status codes, register
// indexes, controller states and the command/status structs.
// No dependencies.
package bpa_pkg;

  // The in-use map is stored as rows of this many bits.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESERVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_STEP  = 2'd1,
    REG_END   = 2'd2
  } reg_index_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_QCHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_CHK
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic row_clr;
    logic row_inc;
    logic div_start;
    logic div_step;
    logic take_q;
    logic take_free;
    logic mul;
    logic commit;
    logic fin_range;
    logic fin_full;
  } bpa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_rel_res;
    logic below_start;
    logic div_last;
    logic q_too_big;
    logic row_any_free;
    logic row_last;
  } bpa_sts_t;

endpackage

>>> sv/bpa_datapath.sv
// Datapath of the bitmap port allocator: configuration registers, serial
// divider, row-organized in-use memory, first-free search and range check.
// Depends on bpa_pkg.
module bpa_datapath import bpa_pkg::*; #(
  parameter int unsigned MAX_PORTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] port_number_i,
  input  bpa_cmd_t    cmd_i,
  output bpa_sts_t    sts_o,
  output logic        done_o,
  output logic [15:0] result_port_o,
  output logic [1:0]  status_o
);

  localparam int unsigned ROWS = (MAX_PORTS + WORD_W - 1) / WORD_W;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IW   = RW + BIT_W;
  localparam int unsigned PW   = IW + 16;

  logic [15:0] start_q, step_q, end_q;
  logic [1:0]  op_q;
  logic [15:0] port_q;
  logic [RW-1:0] row_q;
  logic [IW-1:0] slot_q;
  logic [15:0] rem_q;
  logic [15:0] quo_q;
  logic [3:0]  cnt_q;
  logic [PW-1:0] prod_q;
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] mem_q [ROWS];

  logic        done_q;
  logic [15:0] result_q;
  logic [1:0]  status_q;
  logic        done_d;
  logic [15:0] result_d;
  logic [1:0]  status_d;

  logic [15:0] eff_step;
  logic [16:0] diff;
  logic        fits;
  logic [WORD_W-1:0] valid_mask;
  logic [WORD_W-1:0] free_bits;
  logic [BIT_W-1:0]  first_free;
  logic [RW-1:0]     slot_row;
  logic [RW-1:0]     rd_row;
  logic [RW-1:0]     wr_row;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] new_row;
  logic [16:0]       div_shift;
  logic              div_ge;
  logic              is_alloc;
  logic              is_rel_res;

  assign eff_step   = (step_q == 16'd0) ? 16'd1 : step_q;
  assign diff       = {1'b0, end_q} - {1'b0, start_q};
  assign is_alloc   = (op_q == OP_ALLOC);
  assign is_rel_res = (op_q == OP_RELEASE) || (op_q == OP_RESERVE);
  assign slot_row   = slot_q[IW-1:BIT_W];

  // Slot i lies in range when (i + 1) * step <= end - start.
  assign fits = !diff[16] &&
                (((PW+1)'(prod_q) + (PW+1)'(eff_step)) <= (PW+1)'(diff[15:0]));

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      valid_mask[b] = (32'({row_q, BIT_W'(b)}) < 32'(MAX_PORTS));
    end
    free_bits  = ~rdata_q & valid_mask;
    first_free = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        first_free = BIT_W'(b);
      end
    end
  end

  assign div_shift = {rem_q, quo_q[15]};
  assign div_ge    = (div_shift >= {1'b0, eff_step});

  always_comb begin
    sts_o.is_alloc     = is_alloc;
    sts_o.is_rel_res   = is_rel_res;
    sts_o.below_start  = (port_q < start_q);
    sts_o.div_last     = (cnt_q == 4'd15);
    sts_o.q_too_big    = (32'(quo_q) >= 32'(MAX_PORTS));
    sts_o.row_any_free = |free_bits;
    sts_o.row_last     = (32'(row_q) == 32'(ROWS - 1));
  end

  // Memory port selection.
  always_comb begin
    new_row = rdata_q;
    new_row[slot_q[BIT_W-1:0]] = (op_q != OP_RELEASE);
    rd_row  = cmd_i.mul ? slot_row : row_q;
    wr_en   = cmd_i.clr_wr || (cmd_i.commit && fits);
    wr_row  = cmd_i.clr_wr ? row_q : slot_row;
    wr_data = cmd_i.clr_wr ? '0 : new_row;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_row];
    if (wr_en) begin
      mem_q[wr_row] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 16'd0;
      step_q  <= 16'd1;
      end_q   <= 16'd255;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START: start_q <= cfg_wdata_i;
        REG_STEP:  step_q  <= cfg_wdata_i;
        REG_END:   end_q   <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.row_clr) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + RW'(1);
      end
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      port_q <= port_number_i;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= port_q - start_q;
    end else if (cmd_i.div_step) begin
      // The remainder stays below the step, so it always fits in 16 bits.
      rem_q <= div_ge ? 16'(div_shift - {1'b0, eff_step}) : div_shift[15:0];
      quo_q <= {quo_q[14:0], div_ge};
    end
    if (cmd_i.take_q) begin
      slot_q <= quo_q[IW-1:0];
    end else if (cmd_i.take_free) begin
      slot_q <= {row_q, first_free};
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(slot_q) * PW'(eff_step);
    end
  end

  always_comb begin
    done_d   = 1'b0;
    result_d = result_q;
    status_d = status_q;
    if (cmd_i.commit) begin
      done_d = 1'b1;
      if (fits) begin
        status_d = ST_OK;
        result_d = is_alloc ? (start_q + prod_q[15:0]) : port_q;
      end else if (is_alloc) begin
        status_d = ST_FULL;
        result_d = 16'd0;
      end else begin
        status_d = ST_RANGE;
        result_d = port_q;
      end
    end else if (cmd_i.fin_full) begin
      done_d   = 1'b1;
      status_d = ST_FULL;
      result_d = 16'd0;
    end else if (cmd_i.fin_range) begin
      done_d   = 1'b1;
      status_d = ST_RANGE;
      result_d = is_rel_res ? port_q : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    status_q <= status_d;
  end

  assign done_o        = done_q;
  assign result_port_o = result_q;
  assign status_o      = status_q;

endmodule

>>> sv/bpa_ctrl.sv
// Controller of the bitmap port allocator: sequences the clearing pass,
// the divider, the row scan and the final range check.
// Depends on bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  bpa_sts_t sts_i,
  output bpa_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.row_inc = 1'b1;
        if (sts_i.row_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.row_clr = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_alloc) begin
          state_d = S_SCAN_RD;
        end else if (sts_i.is_rel_res && !sts_i.below_start) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.fin_range = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_QCHK;
        end
      end
      S_QCHK: begin
        if (sts_i.q_too_big) begin
          cmd_o.fin_range = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.take_q = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.row_any_free) begin
          cmd_o.take_free = 1'b1;
          state_d         = S_MUL;
        end else if (sts_i.row_last) begin
          cmd_o.fin_full = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> sv/bitmap_port_allocator.sv
// Top level of the bitmap port allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.

// A request is taken when start is high while busy is low; its one result
// appears on result_port_o and status_o for exactly one cycle with done_o
// high, and cannot be held off. After reset the block clears its in-use
// memory, one 32-slot row per cycle, and busy stays high until the last
// row is cleared. Release and reserve pass through the 16-step serial
// divider that maps a port to its slot; a port below the start of the
// range, or opcode three, is answered without the divider, and a slot
// number at or above MAX_PORTS as soon as the divider is done. Allocate
// reads the 32-slot rows in turn up to and including the one holding a
// free slot; each row costs a memory read and a search. When no row has
// a free slot the answer is full. A new request may be given in the
// cycle of the strobe. Configuration writes are taken at any edge with
// cfg_we_i high and should be made only while the block is idle.
module bitmap_port_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_PORTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] port_number_i,
  output logic        done_o,
  output logic [15:0] result_port_o,
  output logic [1:0]  status_o
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bpa_datapath #(
    .MAX_PORTS (MAX_PORTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .port_number_i (port_number_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .result_port_o (result_port_o),
    .status_o      (status_o)
  );

endmodule

>>> test/bitmap_port_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_port_allocator: it predicts every grant, release
// and reserve result and drives directed, fill and random ranges. Depends on bpa_pkg.
module bitmap_port_allocator_tb;
  import bpa_pkg::*;

  localparam int unsigned MAX_SLOTS   = 256;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE      = 24;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [15:0] port;
    status_e     status;
  } grant_t;

  // Tracks the in-use map and range registers and queues the expected result
  // of every accepted transaction.
  class alloc_tracker;
    logic [15:0] base;
    logic [15:0] stride;
    logic [15:0] limit;
    bit          in_use[MAX_SLOTS];
    grant_t      pending[$];
    int          errors;
    int          n_requests;
    int          n_ok;
    int          n_full;
    int          n_range;

    function new();
      base   = 16'd0;
      stride = 16'd1;
      limit  = 16'd255;
      foreach (in_use[i]) in_use[i] = 1'b0;
    endfunction

    function void set_reg(reg_index_e idx, logic [15:0] value);
      case (idx)
        REG_START: base = value;
        REG_STEP:  stride = value;
        REG_END:   limit = value;
        default: ;
      endcase
    endfunction

    function int unsigned stride_eff();
      return (stride == 16'd0) ? 1 : int'(stride);
    endfunction

    function int unsigned slot_total();
      int unsigned n;
      if (limit < base) return 0;
      n = (limit - base) / stride_eff();
      return (n > MAX_SLOTS) ? MAX_SLOTS : n;
    endfunction

    function void take_request(logic [1:0] op, logic [15:0] port);
      grant_t      g;
      int unsigned total;
      int unsigned slot;
      logic [31:0] addr;
      bit          found;
      g.port = 16'd0;
      g.status = ST_RANGE;
      found = 1'b0;
      n_requests++;
      if (op == OP_ALLOC) begin
        g.status = ST_FULL;
        total = slot_total();
        for (int i = 0; i < total && !found; i++) begin
          if (!in_use[i]) begin
            in_use[i] = 1'b1;
            addr = base + i * stride_eff();
            g.port = addr[15:0];
            g.status = ST_OK;
            found = 1'b1;
          end
        end
      end else if (op == OP_RELEASE || op == OP_RESERVE) begin
        g.port = port;
        if (port >= base) begin
          slot = (port - base) / stride_eff();
          if (slot < slot_total()) begin
            in_use[slot] = (op == OP_RESERVE);
            g.status = ST_OK;
          end
        end
      end
      pending.push_back(g);
    endfunction

    function void check_result(logic [15:0] port, logic [1:0] st);
      grant_t g;
      if (pending.size() == 0) begin
        $error("unexpected result: result_port %0d status %0d", port, st);
        errors++;
        return;
      end
      g = pending.pop_front();
      if (st !== g.status) begin
        $error("status: expected %0d, got %0d", g.status, st);
        errors++;
      end
      if (port !== g.port) begin
        $error("result_port: expected %0d, got %0d", g.port, port);
        errors++;
      end
      case (g.status)
        ST_OK:   n_ok++;
        ST_FULL: n_full++;
        default: n_range++;
      endcase
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = REG_START;
  logic [15:0] cfg_wdata_i   = 16'd0;
  logic        start         = 1'b0;
  logic [1:0]  opcode_i      = OP_ALLOC;
  logic [15:0] port_number_i = 16'd0;
  logic        busy;
  logic        done_o;
  logic [15:0] result_port_o;
  logic [1:0]  status_o;

  alloc_tracker tracker = new();
  int           stall_cycles = 0;
  int           n_settings = 0;

  bitmap_port_allocator #(.MAX_PORTS(MAX_SLOTS)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .port_number_i(port_number_i),
    .done_o       (done_o),
    .result_port_o(result_port_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result checking and the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(result_port_o, status_o);
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL bitmap_port_allocator");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [15:0] port);
    start <= 1'b1;
    opcode_i <= op;
    port_number_i <= port;
    do @(posedge clk_i); while (busy);
    tracker.take_request(op, port);
  endtask

  task automatic pause(input bit allow);
    if (allow && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Waits for every outstanding result, then lets the block settle.
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_range(input logic [15:0] b, input logic [15:0] s,
                               input logic [15:0] e);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_START;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    tracker.set_reg(REG_START, b);
    cfg_index_i <= REG_STEP;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    tracker.set_reg(REG_STEP, s);
    cfg_index_i <= REG_END;
    cfg_wdata_i <= e;
    @(posedge clk_i);
    tracker.set_reg(REG_END, e);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly ports near or inside the range, some just below it, some anywhere.
  function automatic logic [15:0] pick_port();
    int unsigned span;
    int unsigned slot;
    int unsigned r;
    logic [31:0] p;
    span = tracker.stride_eff();
    r = $urandom_range(0, 9);
    if (r < 7) begin
      slot = $urandom_range(0, tracker.slot_total() + 1);
      p = tracker.base + slot * span + $urandom_range(0, span - 1);
      if (p > 32'hFFFF) p = 32'hFFFF;
    end else if (r == 7) begin
      p = tracker.base - $urandom_range(1, 3);
    end else begin
      p = $urandom();
    end
    return p[15:0];
  endfunction

  task automatic pick_random_range(output logic [15:0] b, output logic [15:0] s,
                                   output logic [15:0] e);
    int unsigned tb_base;
    int unsigned tb_step;
    int unsigned tb_end;
    tb_base = $urandom_range(0, 65535);
    tb_step = 1;
    tb_end = 0;
    case ($urandom_range(0, 5))
      0: begin
        tb_step = $urandom_range(1, 40);
        tb_end = tb_base + tb_step * $urandom_range(1, 12) + $urandom_range(0, tb_step - 1);
      end
      1: begin
        tb_step = $urandom_range(1, 8);
        tb_end = tb_base + tb_step * $urandom_range(20, 80);
      end
      2: begin
        tb_base = $urandom_range(0, 1000);
        tb_step = $urandom_range(1, 3);
        tb_end = 65535;
      end
      3: begin
        tb_base = $urandom_range(1, 65535);
        tb_step = $urandom_range(1, 65535);
        tb_end = $urandom_range(0, tb_base - 1);
      end
      4: begin
        tb_step = 0;
        tb_end = tb_base + $urandom_range(0, 20);
      end
      default: begin
        tb_step = $urandom_range(0, 65535);
        tb_end = $urandom_range(0, 65535);
      end
    endcase
    if (tb_end > 65535) tb_end = 65535;
    b = tb_base[15:0];
    s = tb_step[15:0];
    e = tb_end[15:0];
  endtask

  task automatic run_random(input int count, input bit idle_ok, input int alloc_pct);
    int          r;
    logic [1:0]  op;
    logic [15:0] port;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        op = OP_ALLOC;
        port = $urandom();
      end else begin
        r = $urandom_range(0, 19);
        op = (r < 9) ? OP_RELEASE : (r < 18) ? OP_RESERVE : OP_UNUSED;
        port = pick_port();
      end
      send_request(op, port);
      pause(idle_ok);
    end
  endtask

  initial begin
    logic [15:0] b;
    logic [15:0] s;
    logic [15:0] e;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // Default range: repeated writes, the last slot, the end port and opcode three.
    program_range(16'd0, 16'd1, 16'd255);
    send_request(OP_RELEASE, 16'd0);
    send_request(OP_RESERVE, 16'd0);
    send_request(OP_RESERVE, 16'd0);
    pause(1'b1);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_RELEASE, 16'd0);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_RESERVE, 16'd254);
    send_request(OP_RESERVE, 16'd255);
    send_request(OP_RELEASE, 16'hFFFF);
    send_request(OP_UNUSED, 16'hFFFF);
    send_request(OP_RELEASE, 16'hAAAA);
    drain();

    // Three slots of step seven: truncation, below start, running full.
    program_range(16'd1000, 16'd7, 16'd1026);
    send_request(OP_RELEASE, 16'd999);
    send_request(OP_RESERVE, 16'd1013);
    send_request(OP_ALLOC, 16'h5555);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_RESERVE, 16'd1021);
    send_request(OP_RELEASE, 16'd1020);
    drain();

    // End below start leaves no slots at all.
    program_range(16'd500, 16'hFFFF, 16'd100);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_RELEASE, 16'd500);
    drain();

    // A zero step behaves as a step of one.
    program_range(16'hFFFC, 16'd0, 16'hFFFF);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_RESERVE, 16'hFFFF);
    send_request(OP_RELEASE, 16'hFFFE);
    drain();

    // Saturated slot count, then fill the whole map with allocations.
    program_range(16'd0, 16'd1, 16'hFFFF);
    send_request(OP_RELEASE, 16'hFFFF);
    send_request(OP_RELEASE, 16'd255);
    run_random(280, 1'b1, 85);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      pick_random_range(b, s, e);
      program_range(b, s, e);
      run_random(55, phase != 6, 40);
      drain();
    end

    $display("Covered %0d requests over %0d range settings, from empty to saturated.",
             tracker.n_requests, n_settings);
    $display("Results: %0d ok, %0d full, %0d out of range.",
             tracker.n_ok, tracker.n_full, tracker.n_range);
    if (tracker.errors == 0) begin
      $display("PASS bitmap_port_allocator");
    end else begin
      $display("FAIL bitmap_port_allocator");
    end
    $finish;
  end

endmodule

>>> bitmap_port_allocator.f
sv/bpa_pkg.sv
sv/bpa_datapath.sv
sv/bpa_ctrl.sv
sv/bitmap_port_allocator.sv
test/bitmap_port_allocator_tb.sv
